### rtl/core/rotation_matrix_to_zyx_euler_macros.svh
// Assertion helpers for the Euler angle block.
`ifndef ROTATION_MATRIX_TO_ZYX_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_ZYX_EULER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RMZ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define RMZ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/rmz_pkg.sv
`timescale 1ns / 1ps
package rmz_pkg;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int ANG_W = 28;
    localparam int VEC_W = 36;
    localparam int OUT_W = 16;
    localparam logic signed [ANG_W-1:0] PI_Q = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 28'sd26353589;
    localparam logic signed [VEC_W-1:0] KINV_Q30 = 36'sd652032874;
    localparam int OUT_LIMIT = 25736;

    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic signed [ANG_W-1:0] r;
        case (i)
            0: r = 28'sd13176795;
            1: r = 28'sd7778716;
            2: r = 28'sd4110060;
            3: r = 28'sd2086331;
            4: r = 28'sd1047214;
            5: r = 28'sd524117;
            6: r = 28'sd262123;
            7: r = 28'sd131069;
            default: r = (i < 25) ? (ANG_W'(1) <<< (24 - i)) : '0;
        endcase
        return r;
    endfunction

    function automatic logic [OUT_W-1:0] angle_out(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W-1:0] q;
        q = (z + ANG_W'(1024)) >>> 11;
        if (q > ANG_W'(OUT_LIMIT))
            q = ANG_W'(OUT_LIMIT);
        if (q < -ANG_W'(OUT_LIMIT))
            q = -ANG_W'(OUT_LIMIT);
        return q[OUT_W-1:0];
    endfunction
endpackage

### rtl/core/rotation_matrix_to_zyx_euler.sv
`timescale 1ns / 1ps
// Z-Y-X Euler angles (yaw phi, pitch theta, roll psi, Q3.13 radians) from seven
// elements of a rotation matrix. Fully pipelined: one matrix per cycle while the
// skid is empty, through three chained CORDIC pipelines of CORDIC_STAGES+1
// registers each (atan2, sin/cos, atan2 for theta and psi side by side), a
// product register and a sum register, and one output register with a skid
// beside it. The whole pipe advances when the skid has room.
module rotation_matrix_to_zyx_euler #(
    parameter int CORDIC_STAGES = rmz_pkg::CORDIC_STAGES_DEF,
    parameter int ELEMENT_WIDTH = rmz_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // m00, m10, m20, m01, m11, m02, m12 (ELEMENT_WIDTH each), zero padded
    input  logic [((7*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // yaw_phi, pitch_theta, roll_psi
    output logic [47:0] m_axis_tdata
);
    import rmz_pkg::*;
    `include "rotation_matrix_to_zyx_euler_macros.svh"
    localparam int EW = ELEMENT_WIDTH;
    localparam int SW = 5 * VEC_W;
    localparam int SW2 = 4 * VEC_W + OUT_W;
    // elements and sin/cos both fit 32 bits signed
    localparam int MUL_W = 32;

    logic en;
    logic signed [VEC_W-1:0] e [7];
    always_comb
    begin
        for (int k = 0; k < 7; k++)
            e[k] = VEC_W'($signed(s_axis_tdata[k*EW +: EW])) <<< (32 - EW);
    end

    // stage A: phi
    logic a_v;
    logic signed [ANG_W-1:0] phi;
    logic [SW-1:0] a_side;
    rmz_atan2 #(.STAGES(CORDIC_STAGES), .SIDE_W(SW)) u_phi (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s_axis_tvalid),
        .y_in(e[1]), .x_in(e[0]),
        .side_in({e[6], e[5], e[4], e[3], e[2]}),
        .out_valid(a_v), .z_out(phi), .side_out(a_side));

    // carry nx, ny too: pack nx,ny via stage A side? use delayed copy
    logic signed [VEC_W-1:0] nxy_d [CORDIC_STAGES+1][2];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxy_d[0][0] <= e[0];
            nxy_d[0][1] <= e[1];
            for (int i = 1; i <= CORDIC_STAGES; i++)
            begin
                nxy_d[i][0] <= nxy_d[i-1][0];
                nxy_d[i][1] <= nxy_d[i-1][1];
            end
        end
    end

    // stage B: sin/cos
    logic b_v;
    logic signed [VEC_W-1:0] co, si;
    logic [SW2+2*VEC_W-1:0] b_side;
    rmz_sincos #(.STAGES(CORDIC_STAGES), .SIDE_W(SW2+2*VEC_W)) u_sc (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(a_v), .z_in(phi),
        .side_in({nxy_d[CORDIC_STAGES][1], nxy_d[CORDIC_STAGES][0], a_side[SW-1:VEC_W],
                  angle_out(phi)}),
        .out_valid(b_v), .cos_out(co), .sin_out(si), .side_out(b_side));

    logic [OUT_W-1:0] phi_q;
    logic signed [VEC_W-1:0] nz;
    logic signed [MUL_W-1:0] ox, oy, ax, ay, nx, ny, co_m, si_m;
    always_comb
    begin
        phi_q = b_side[OUT_W-1:0];
        ox = b_side[OUT_W +: MUL_W];
        oy = b_side[OUT_W+VEC_W +: MUL_W];
        ax = b_side[OUT_W+2*VEC_W +: MUL_W];
        ay = b_side[OUT_W+3*VEC_W +: MUL_W];
        nx = b_side[OUT_W+4*VEC_W +: MUL_W];
        ny = b_side[OUT_W+5*VEC_W +: MUL_W];
        co_m = co[MUL_W-1:0];
        si_m = si[MUL_W-1:0];
    end
    logic signed [VEC_W-1:0] nz_d [CORDIC_STAGES+1];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nz_d[0] <= a_side[VEC_W-1:0];
            for (int i = 1; i <= CORDIC_STAGES; i++)
                nz_d[i] <= nz_d[i-1];
        end
    end
    // a_side nz comes out of stage A with phi; nz_d holds it through as many registers as sincos
    assign nz = nz_d[CORDIC_STAGES];

    // product stages: register products, then sum and shift
    logic p_v_reg, q_v_reg;
    logic signed [2*MUL_W-1:0] p_reg [6];
    logic signed [VEC_W-1:0] nzp_reg, nzq_reg;
    logic [OUT_W-1:0] phip_reg, phiq_reg;
    logic signed [VEC_W-1:0] den_reg, nump_reg, denp_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_v_reg <= 1'b0;
            q_v_reg <= 1'b0;
        end
        else if (en)
        begin
            p_v_reg <= b_v;
            q_v_reg <= p_v_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= co_m * nx;
            p_reg[1] <= si_m * ny;
            p_reg[2] <= si_m * ax;
            p_reg[3] <= co_m * ay;
            p_reg[4] <= co_m * oy;
            p_reg[5] <= si_m * ox;
            nzp_reg <= nz;
            phip_reg <= phi_q;
            den_reg <= VEC_W'((p_reg[0] + p_reg[1]) >>> 30);
            nump_reg <= VEC_W'((p_reg[2] - p_reg[3]) >>> 30);
            denp_reg <= VEC_W'((p_reg[4] - p_reg[5]) >>> 30);
            nzq_reg <= -nzp_reg;
            phiq_reg <= phip_reg;
        end
    end

    // stage C: theta and psi
    logic c_v, c_v2;
    logic signed [ANG_W-1:0] theta, psi;
    logic [OUT_W-1:0] c_phi;
    logic [OUT_W-1:0] unused_side;
    rmz_atan2 #(.STAGES(CORDIC_STAGES), .SIDE_W(OUT_W)) u_theta (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_v_reg),
        .y_in(nzq_reg), .x_in(den_reg), .side_in(phiq_reg),
        .out_valid(c_v), .z_out(theta), .side_out(c_phi));
    rmz_atan2 #(.STAGES(CORDIC_STAGES), .SIDE_W(OUT_W)) u_psi (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_v_reg),
        .y_in(nump_reg), .x_in(denp_reg), .side_in(phiq_reg),
        .out_valid(c_v2), .z_out(psi), .side_out(unused_side));

    // output register plus skid
    logic out_v_reg, skid_v_reg;
    logic [47:0] out_reg, skid_reg;
    logic [47:0] res;
    assign res = {angle_out(psi), angle_out(theta), c_phi | (unused_side & 16'h0)};
    assign en = !skid_v_reg;
    assign s_axis_tready = en;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (!out_v_reg || m_axis_tready)
            begin
                if (skid_v_reg)
                begin
                    out_v_reg <= 1'b1;
                    skid_v_reg <= 1'b0;
                end
                else
                    out_v_reg <= c_v;
            end
            else if (c_v && en)
                skid_v_reg <= 1'b1;
        end
    end
    always_ff @(posedge clk)
    begin
        if (!out_v_reg || m_axis_tready)
            out_reg <= skid_v_reg ? skid_reg : res;
        else if (c_v && en)
            skid_reg <= res;
    end
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = out_reg;

    `RMZ_ASSERT_IMPL(a_lanes_match, c_v != c_v2, 1'b0)
    `RMZ_ASSERT_NEXT(a_skid_drains, skid_v_reg && m_axis_tready, !skid_v_reg)
    `RMZ_ASSERT_IMPL(a_skid_full, skid_v_reg, out_v_reg)
endmodule

### rtl/core/rmz_atan2.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC, one micro-rotation per stage.
// Side data rides along.
module rmz_atan2 #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [rmz_pkg::VEC_W-1:0] y_in,
    input  logic signed [rmz_pkg::VEC_W-1:0] x_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic out_valid,
    output logic signed [rmz_pkg::ANG_W-1:0] z_out,
    output logic [SIDE_W-1:0] side_out
);
    import rmz_pkg::*;
    logic signed [VEC_W-1:0] x_reg [STAGES+1];
    logic signed [VEC_W-1:0] y_reg [STAGES+1];
    logic signed [ANG_W-1:0] z_reg [STAGES+1];
    logic fix_reg [STAGES+1];
    logic signed [ANG_W-1:0] fixz_reg [STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];
    logic v_reg [STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= STAGES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            // zero ordinate gives an exact answer
            fix_reg[0] <= (y_in == '0);
            fixz_reg[0] <= (x_in < 0) ? PI_Q : '0;
            if (x_in < 0)
            begin
                z_reg[0] <= (y_in > 0) ? PI_Q : -PI_Q;
                x_reg[0] <= -x_in;
                y_reg[0] <= -y_in;
            end
            else
            begin
                z_reg[0] <= '0;
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
            end
            for (int i = 1; i <= STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                fix_reg[i] <= fix_reg[i-1];
                fixz_reg[i] <= fixz_reg[i-1];
                if (y_reg[i-1] > 0)
                begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] + atan_entry(i-1);
                end
                else
                begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] - atan_entry(i-1);
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign z_out = fix_reg[STAGES] ? fixz_reg[STAGES] : z_reg[STAGES];
    assign side_out = side_reg[STAGES];
endmodule

### rtl/core/rmz_sincos.sv
`timescale 1ns / 1ps
// Pipelined rotation CORDIC: cos/sin in Q.30 of a Q.24 angle.
module rmz_sincos #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 8
) (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  logic signed [rmz_pkg::ANG_W-1:0] z_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic out_valid,
    output logic signed [rmz_pkg::VEC_W-1:0] cos_out,
    output logic signed [rmz_pkg::VEC_W-1:0] sin_out,
    output logic [SIDE_W-1:0] side_out
);
    import rmz_pkg::*;
    logic signed [VEC_W-1:0] x_reg [STAGES+1];
    logic signed [VEC_W-1:0] y_reg [STAGES+1];
    logic signed [ANG_W-1:0] z_reg [STAGES+1];
    logic neg_reg [STAGES+1];
    logic [SIDE_W-1:0] side_reg [STAGES+1];
    logic v_reg [STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= STAGES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            x_reg[0] <= KINV_Q30;
            y_reg[0] <= '0;
            if (z_in > HALF_PI_Q)
            begin
                z_reg[0] <= z_in - PI_Q;
                neg_reg[0] <= 1'b1;
            end
            else if (z_in < -HALF_PI_Q)
            begin
                z_reg[0] <= z_in + PI_Q;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0] <= z_in;
                neg_reg[0] <= 1'b0;
            end
            for (int i = 1; i <= STAGES; i++)
            begin
                side_reg[i] <= side_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                if (z_reg[i-1] >= 0)
                begin
                    x_reg[i] <= x_reg[i-1] - (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] + (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] - atan_entry(i-1);
                end
                else
                begin
                    x_reg[i] <= x_reg[i-1] + (y_reg[i-1] >>> (i-1));
                    y_reg[i] <= y_reg[i-1] - (x_reg[i-1] >>> (i-1));
                    z_reg[i] <= z_reg[i-1] + atan_entry(i-1);
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign cos_out = neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
    assign sin_out = neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    assign side_out = side_reg[STAGES];
endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import rmz_pkg::*;

    localparam int EW = 16;
    localparam int DW = ((7 * EW + 7) / 8) * 8;
    localparam int PIPE_DEPTH = 3 * CORDIC_STAGES_DEF + 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;

    logic [47:0] angles_q[$];
    int errors = 0;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    rotation_matrix_to_zyx_euler i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    // ---------------- angle predictor ----------------
    function automatic longint arctan_step(input int i);
        case (i)
            0: return 64'sd13176795;
            1: return 64'sd7778716;
            2: return 64'sd4110060;
            3: return 64'sd2086331;
            4: return 64'sd1047214;
            5: return 64'sd524117;
            6: return 64'sd262123;
            7: return 64'sd131069;
            default: return (i < 25) ? (64'sd1 <<< (24 - i)) : 64'sd0;
        endcase
    endfunction

    function automatic longint vector_angle(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint z;
        longint nx;
        x = x_in;
        y = y_in;
        z = 0;
        if (y == 0)
            return (x < 0) ? longint'(PI_Q) : 0;
        if (x < 0)
        begin
            z = (y > 0) ? longint'(PI_Q) : -longint'(PI_Q);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            else
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end
            x = nx;
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint z_in, output longint c, output longint s);
        longint x;
        longint y;
        longint z;
        longint nx;
        bit flip;
        x = longint'(KINV_Q30);
        y = 0;
        z = z_in;
        flip = 1'b0;
        // fold into +-pi/2, negate both results afterwards
        if (z > longint'(HALF_PI_Q))
        begin
            z -= longint'(PI_Q);
            flip = 1'b1;
        end
        else if (z < -longint'(HALF_PI_Q))
        begin
            z += longint'(PI_Q);
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES_DEF; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan_step(i);
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic [15:0] angle_q13(input longint z);
        longint q;
        q = (z + 1024) >>> 11;
        if (q > OUT_LIMIT)
            q = OUT_LIMIT;
        if (q < -OUT_LIMIT)
            q = -OUT_LIMIT;
        return q[15:0];
    endfunction

    task automatic predict_euler(input logic [DW-1:0] data, output logic [47:0] angles);
        longint e[7];
        longint co;
        longint si;
        longint phi;
        longint theta;
        longint psi;
        for (int k = 0; k < 7; k++)
            e[k] = longint'($signed(data[k*EW +: EW])) * (64'sd1 <<< (32 - EW));
        phi = vector_angle(e[1], e[0]);
        rotate_unit(phi, co, si);
        theta = vector_angle(-e[2], (co * e[0] + si * e[1]) >>> 30);
        psi = vector_angle((si * e[5] - co * e[6]) >>> 30, (co * e[4] - si * e[3]) >>> 30);
        angles = {angle_q13(psi), angle_q13(theta), angle_q13(phi)};
    endtask

    // ---------------- stimulus ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // el order: m00, m10, m20, m01, m11, m02, m12
    task automatic send_matrix(input logic signed [15:0] el[7]);
        logic [DW-1:0] data;
        logic [47:0] angles;
        bit ready;
        int gap;
        for (int k = 0; k < 7; k++)
            data[k*EW +: EW] = el[k];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        do
        begin
            @(negedge clk);
            ready = s_axis_tready;
            @(posedge clk);
        end
        while (!ready);
        predict_euler(data, angles);
        angles_q.push_back(angles);
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_elems(input int a, b, c, d, e, f, g);
        logic signed [15:0] el[7];
        el = '{a[15:0], b[15:0], c[15:0], d[15:0], e[15:0], f[15:0], g[15:0]};
        send_matrix(el);
    endtask

    function automatic logic signed [15:0] to_q14(input real v);
        real r;
        r = v * 16384.0;
        if (r > 32767.0)
            r = 32767.0;
        if (r < -32768.0)
            r = -32768.0;
        return 16'($rtoi(r < 0.0 ? r - 0.5 : r + 0.5));
    endfunction

    task automatic send_pose(input real a, input real b, input real c);
        logic signed [15:0] el[7];
        real ca, sa, cb, sb, cc, sc;
        ca = $cos(a); sa = $sin(a);
        cb = $cos(b); sb = $sin(b);
        cc = $cos(c); sc = $sin(c);
        el[0] = to_q14(ca * cb);
        el[1] = to_q14(sa * cb);
        el[2] = to_q14(-sb);
        el[3] = to_q14(ca * sb * sc - sa * cc);
        el[4] = to_q14(sa * sb * sc + ca * cc);
        el[5] = to_q14(ca * sb * cc + sa * sc);
        el[6] = to_q14(sa * sb * cc - ca * sc);
        send_matrix(el);
    endtask

    function automatic real rand_angle(input real span);
        return ($urandom_range(0, 200000) / 100000.0 - 1.0) * span;
    endfunction

    task automatic test_directed();
        send_elems(0, 0, 0, 0, 0, 0, 0);
        send_elems(16384, 0, 0, 0, 16384, 0, 0);                  // identity
        send_elems(-16384, 0, 0, 0, -16384, 0, 0);                // zero ordinate, x < 0
        send_elems(-16384, 1, 0, 0, 16384, 0, 0);                 // negative abscissa, y > 0
        send_elems(-16384, -1, 0, 0, 16384, 0, 0);                // negative abscissa, y < 0
        send_elems(0, 16384, 0, -16384, 0, 0, 0);                 // phi = pi/2
        send_elems(0, -16384, 0, 16384, 0, 0, 0);
        send_elems(0, 0, -16384, 0, 16384, 16384, 0);             // gimbal lock
        send_elems(0, 0, 16384, 0, 16384, -16384, 0);
        send_elems(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_elems(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
        send_elems(32767, -32768, 32767, -32768, 32767, -32768, 32767);
        send_elems(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
        send_elems(-32768, 0, 32767, 0, -32768, 0, 32767);
        send_elems(1, 0, 0, 0, 0, 0, 0);
        send_elems(-1, -1, -1, -1, -1, -1, -1);
        send_pose(3.0, 0.5, -2.9);                                // |phi| > pi/2
        send_pose(-3.0, -0.7, 2.5);
        send_pose(1.7, 1.2, 0.3);
        send_pose(-1.7, -1.5, -1.0);
        send_pose(0.2, 0.0, 3.1);
    endtask

    task automatic test_random(input int count);
        logic signed [15:0] el[7];
        for (int n = 0; n < count; n++)
        begin
            if ((n % 400) < 60)
                tx_calm = 1'b1;
            else
                tx_calm = 1'b0;
            rx_calm = ((n % 500) >= 250 && (n % 500) < 300);
            if ($urandom_range(0, 99) < 60)
                send_pose(rand_angle(3.14159), rand_angle(1.5708), rand_angle(3.14159));
            else
            begin
                for (int k = 0; k < 7; k++)
                    el[k] = ($urandom_range(0, 9) == 0) ? 16'sd0 : 16'($urandom);
                send_matrix(el);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (angles_q.size() != 0)
            @(posedge clk);
        send_pose(0.5, -0.5, 1.0);
        send_elems(-32768, 0, 0, 0, 0, 0, 0);
    endtask

    // ---------------- receiver ----------------
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!rx_calm && $urandom_range(0, 99) < 25)
        begin
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // outputs are stable between the falling edge and the accepting rising edge
    always @(negedge clk)
    begin
        logic [47:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angles_q.size() == 0)
            begin
                $display("%0t: unexpected item %h", $realtime, m_axis_tdata);
                errors++;
            end
            else
            begin
                want = angles_q.pop_front();
                if (want[15:0] !== m_axis_tdata[15:0])
                begin
                    $display("%0t: yaw_phi exp %0d got %0d", $realtime,
                             $signed(want[15:0]), $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (want[31:16] !== m_axis_tdata[31:16])
                begin
                    $display("%0t: pitch_theta exp %0d got %0d", $realtime,
                             $signed(want[31:16]), $signed(m_axis_tdata[31:16]));
                    errors++;
                end
                if (want[47:32] !== m_axis_tdata[47:32])
                begin
                    $display("%0t: roll_psi exp %0d got %0d", $realtime,
                             $signed(want[47:32]), $signed(m_axis_tdata[47:32]));
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_drain_pause();
        test_random(1030);
        s_axis_tvalid <= 1'b0;
        while (angles_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
        if (errors == 0 && angles_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
